// File: rtl/aes128_ecb_ctr_variable_rounds_assert.svh
// Assertion macros for the variable-round AES block
`ifndef AES128_ECB_CTR_VARIABLE_ROUNDS_ASSERT_SVH
`define AES128_ECB_CTR_VARIABLE_ROUNDS_ASSERT_SVH
`ifndef SYNTHESIS
`define AES_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define AES_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define AES_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define AES_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/aes_pkg.sv
// Types, tables and round functions shared by the AES block
package aes_pkg;

    typedef enum logic [2:0] {
        ST_KEXP,
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } t_state;

    typedef enum logic [2:0] {
        REG_KEY_HIGH    = 3'd0,
        REG_KEY_LOW     = 3'd1,
        REG_ROUND_COUNT = 3'd2,
        REG_CHAIN_MODE  = 3'd3,
        REG_DIRECTION   = 3'd4
    } t_reg_idx;

    typedef logic [7:0] t_sbox [256];

    localparam t_sbox SBOX = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam t_sbox INV_SBOX = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic logic [7:0] xt(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function automatic logic [127:0] sbox_layer(input logic [127:0] s, input logic inv);
        logic [127:0] o;
        for (int i = 0; i < 16; i++) begin
            o[127-8*i -: 8] = inv ? INV_SBOX[s[127-8*i -: 8]] : SBOX[s[127-8*i -: 8]];
        end
        return o;
    endfunction

    function automatic logic [127:0] row_shift(input logic [127:0] s, input logic inv);
        logic [127:0] o;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                if (inv) begin
                    o[127-8*(((c+r)%4)*4+r) -: 8] = s[127-8*(c*4+r) -: 8];
                end else begin
                    o[127-8*(c*4+r) -: 8] = s[127-8*(((c+r)%4)*4+r) -: 8];
                end
            end
        end
        return o;
    endfunction

    function automatic logic [127:0] mix_cols(input logic [127:0] s, input logic inv);
        logic [127:0] o;
        logic [7:0] a [4];
        logic [7:0] a2 [4];
        logic [7:0] a4 [4];
        logic [7:0] a8 [4];
        logic [7:0] m [4];
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) begin
                a[k] = s[127-8*(c*4+k) -: 8];
                a2[k] = xt(a[k]);
                a4[k] = xt(a2[k]);
                a8[k] = xt(a4[k]);
            end
            for (int r = 0; r < 4; r++) begin
                o[127-8*(c*4+r) -: 8] = 8'h00;
                for (int k = 0; k < 4; k++) begin
                    unique case ((k - r) & 3)
                        0: m[k] = inv ? (a8[k] ^ a4[k] ^ a2[k]) : a2[k];
                        1: m[k] = inv ? (a8[k] ^ a2[k] ^ a[k]) : (a2[k] ^ a[k]);
                        2: m[k] = inv ? (a8[k] ^ a4[k] ^ a[k]) : a[k];
                        default: m[k] = inv ? (a8[k] ^ a[k]) : a[k];
                    endcase
                    o[127-8*(c*4+r) -: 8] = o[127-8*(c*4+r) -: 8] ^ m[k];
                end
            end
        end
        return o;
    endfunction

endpackage

// File: rtl/aes128_ecb_ctr_variable_rounds.sv
// Variable-round AES-128 block unit with ECB and counter modes, top level
// One round unit iterates over the state, reading each round key word by word
// from a key RAM; a 128-bit round key is assembled from four words. Each round
// waits on the four single-word reads of its round key. After reset and after
// every key write the key schedule is rebuilt, one word a cycle, while no
// block is accepted. The result stays in an output register until taken.
module aes128_ecb_ctr_variable_rounds #(
    parameter int MAX_ROUND_COUNT = 15
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_block_high,
    input  logic [63:0] i_block_low,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_result_high,
    output logic [63:0] o_result_low
);
    import aes_pkg::*;
`include "aes128_ecb_ctr_variable_rounds_assert.svh"

    localparam int KW = (MAX_ROUND_COUNT + 1) * 4;
    localparam int AW = $clog2(KW);
    localparam int RW = $clog2(MAX_ROUND_COUNT + 1);

    t_state r_state, n_state;
    logic [63:0] r_key_high, r_key_low;
    logic [3:0] r_round_count;
    logic r_chain_mode, r_direction;
    logic [127:0] r_ctr;
    logic [127:0] r_st, n_st;
    logic [127:0] r_blk;
    logic [127:0] r_rk;
    logic [AW:0] r_kidx, n_kidx;
    logic [7:0] r_rcon, n_rcon;
    logic [31:0] r_w [4];
    logic [31:0] n_w [4];
    logic [RW-1:0] r_rnd, n_rnd;
    logic [2:0] r_ph, n_ph;
    logic [RW-1:0] r_nr;
    logic r_dec, r_mode;
    logic [127:0] r_out;
    logic r_ovalid;

    logic ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [31:0] ram_wdata, ram_rdata;
    logic [31:0] kexp_w;
    logic [RW-1:0] key_sel;
    logic [127:0] rk_full;
    logic [127:0] rnd_enc, rnd_dec;

    aes_ram #(.WIDTH(32), .DEPTH(KW)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_ready = (r_state == ST_IDLE) && !r_ovalid;
    assign o_valid = r_ovalid;
    assign o_result_high = r_out[127:64];
    assign o_result_low = r_out[63:0];

    // last word of the round key comes straight from the RAM
    assign rk_full = {r_rk[95:0], ram_rdata};

    always_comb begin
        if (r_kidx[1:0] == 2'd0) begin
            kexp_w = r_w[0] ^ sub_word({r_w[3][23:0], r_w[3][31:24]}) ^ {r_rcon, 24'h0};
        end else begin
            kexp_w = r_w[0] ^ r_w[3];
        end
    end

    always_comb begin
        rnd_enc = row_shift(sbox_layer(r_st, 1'b0), 1'b0);
        if (r_rnd != r_nr) begin
            rnd_enc = mix_cols(rnd_enc, 1'b0);
        end
        rnd_enc = rnd_enc ^ rk_full;
        rnd_dec = r_st ^ rk_full;
        if (r_rnd != r_nr) begin
            rnd_dec = sbox_layer(row_shift(mix_cols(rnd_dec, 1'b1), 1'b1), 1'b1);
        end
    end

    // round key index selected for the word fetch
    assign key_sel = r_dec ? RW'(r_nr - r_rnd) : r_rnd;

    always_comb begin
        n_state = r_state;
        n_st = r_st;
        n_kidx = r_kidx;
        n_rcon = r_rcon;
        n_rnd = r_rnd;
        n_ph = r_ph;
        for (int i = 0; i < 4; i++) begin
            n_w[i] = r_w[i];
        end
        ram_we = 1'b0;
        ram_waddr = r_kidx[AW-1:0];
        ram_wdata = kexp_w;
        ram_raddr = {key_sel, r_ph[1:0]};
        unique case (r_state)
            ST_KEXP: begin
                ram_we = 1'b1;
                ram_wdata = (r_kidx < (AW+1)'(4)) ? r_w[r_kidx[1:0]] : kexp_w;
                n_kidx = r_kidx + 1'b1;
                if (r_kidx[1:0] == 2'd0 && r_kidx != '0) begin
                    n_rcon = xt(r_rcon);
                end
                if (r_kidx >= (AW+1)'(4)) begin
                    n_w[0] = r_w[1];
                    n_w[1] = r_w[2];
                    n_w[2] = r_w[3];
                    n_w[3] = kexp_w;
                end
                if (r_kidx == (AW+1)'(KW - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_valid && o_ready) begin
                    n_state = ST_RUN;
                    n_rnd = '0;
                    n_ph = '0;
                    n_st = r_chain_mode ? r_ctr : {i_block_high, i_block_low};
                end
            end
            ST_RUN: begin
                n_ph = r_ph + 1'b1;
                if (r_ph == 3'd4) begin
                    n_ph = '0;
                    if (r_rnd == '0) begin
                        n_st = r_st ^ rk_full;
                        if (r_dec) begin
                            n_st = sbox_layer(row_shift(r_st ^ rk_full, 1'b1), 1'b1);
                        end
                    end else begin
                        n_st = r_dec ? rnd_dec : rnd_enc;
                    end
                    if (r_rnd == r_nr) begin
                        n_state = ST_HOLD;
                    end
                    n_rnd = r_rnd + 1'b1;
                end
            end
            ST_HOLD: begin
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
        if (i_cfg_we && i_cfg_idx == REG_KEY_HIGH) begin
            n_w[0] = i_cfg_data[63:32];
            n_w[1] = i_cfg_data[31:0];
            n_w[2] = r_key_low[63:32];
            n_w[3] = r_key_low[31:0];
        end else if (i_cfg_we && i_cfg_idx == REG_KEY_LOW) begin
            n_w[0] = r_key_high[63:32];
            n_w[1] = r_key_high[31:0];
            n_w[2] = i_cfg_data[63:32];
            n_w[3] = i_cfg_data[31:0];
        end
        if (i_cfg_we && (i_cfg_idx == REG_KEY_HIGH || i_cfg_idx == REG_KEY_LOW)) begin
            n_state = ST_KEXP;
            n_kidx = '0;
            n_rcon = 8'h01;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_KEXP;
            r_key_high <= '0;
            r_key_low <= '0;
            r_round_count <= 4'd10;
            r_chain_mode <= 1'b0;
            r_direction <= 1'b0;
            r_ctr <= '0;
            r_kidx <= '0;
            r_rcon <= 8'h01;
            r_ovalid <= 1'b0;
            r_rnd <= '0;
            r_ph <= '0;
            for (int i = 0; i < 4; i++) begin
                r_w[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_kidx <= n_kidx;
            r_rcon <= n_rcon;
            r_rnd <= n_rnd;
            r_ph <= n_ph;
            for (int i = 0; i < 4; i++) begin
                r_w[i] <= n_w[i];
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_KEY_HIGH: r_key_high <= i_cfg_data;
                    REG_KEY_LOW: r_key_low <= i_cfg_data;
                    REG_ROUND_COUNT: r_round_count <= i_cfg_data[3:0];
                    REG_CHAIN_MODE: r_chain_mode <= i_cfg_data[0];
                    REG_DIRECTION: r_direction <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (r_state == ST_IDLE && i_valid && o_ready) begin
                r_blk <= {i_block_high, i_block_low};
                r_mode <= r_chain_mode;
                r_dec <= r_direction && !r_chain_mode;
                if (r_round_count == 4'd0) begin
                    r_nr <= RW'(1);
                end else if (32'(r_round_count) > MAX_ROUND_COUNT) begin
                    r_nr <= RW'(MAX_ROUND_COUNT);
                end else begin
                    r_nr <= RW'(r_round_count);
                end
            end
            if (r_state == ST_RUN && r_ph == 3'd4 && r_rnd == r_nr && r_mode) begin
                r_ctr <= r_ctr + 128'd1;
            end
            if (r_state == ST_HOLD) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_st <= n_st;
        if (r_state == ST_RUN && r_ph >= 3'd1 && r_ph <= 3'd4) begin
            r_rk <= {r_rk[95:0], ram_rdata};
        end
        if (r_state == ST_HOLD) begin
            r_out <= r_mode ? (r_st ^ r_blk) : r_st;
        end
    end

    `AES_ASSERT_IMPL(a_out_hold, i_clk, i_rst_n, r_ovalid, r_state != ST_RUN)
    `AES_ASSERT_NEXT(a_accept_runs, i_clk, i_rst_n, i_valid && o_ready && !i_cfg_we,
        r_state == ST_RUN)
    `AES_ASSERT_IMPL(a_round_bound, i_clk, i_rst_n, r_state == ST_RUN, r_rnd <= r_nr)
endmodule

// File: rtl/aes_ram.sv
// Generic single-port-write, one-read RAM with registered read data
module aes_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
